/* design/dxt_pkg.sv */
// Shared constants and texel arithmetic for the DXT block decoder.
package dxt_pkg;

   localparam logic [1:0] FMT_DXT1 = 2'd0;
   localparam logic [1:0] FMT_DXT3 = 2'd1;
   localparam logic [1:0] FMT_DXT5 = 2'd2;

   localparam int unsigned TEXELS     = 16;
   localparam int unsigned TEXEL_BITS = $clog2(TEXELS);
   localparam logic [TEXEL_BITS-1:0] LAST_TEXEL = TEXEL_BITS'(TEXELS - 1);

   // Reciprocal constants: floor(x / d) == (x * RECIP) >> SHIFT over the used input range.
   localparam logic [11:0] RECIP3 = 12'd2731;
   localparam int unsigned SHIFT3 = 13;
   localparam logic [11:0] RECIP5 = 12'd3277;
   localparam int unsigned SHIFT5 = 14;
   localparam logic [11:0] RECIP7 = 12'd2341;
   localparam int unsigned SHIFT7 = 14;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   function automatic logic [7:0] widen5(input logic [4:0] v);
      return {v, v[4:2]};
   endfunction

   function automatic logic [7:0] widen6(input logic [5:0] v);
      return {v, v[5:4]};
   endfunction

   function automatic logic [7:0] widen4(input logic [3:0] v);
      return {v, v};
   endfunction

   function automatic rgb_type unpack565(input logic [15:0] e);
      rgb_type c;
      c.red   = widen5(e[15:11]);
      c.green = widen6(e[10:5]);
      c.blue  = widen5(e[4:0]);
      return c;
   endfunction

   function automatic logic [7:0] div3(input logic [9:0] x);
      logic [21:0] p;
      p = 22'(x) * 22'(RECIP3);
      return 8'(p >> SHIFT3);
   endfunction

   function automatic logic [7:0] div5(input logic [10:0] x);
      logic [22:0] p;
      p = 23'(x) * 23'(RECIP5);
      return 8'(p >> SHIFT5);
   endfunction

   function automatic logic [7:0] div7(input logic [10:0] x);
      logic [22:0] p;
      p = 23'(x) * 23'(RECIP7);
      return 8'(p >> SHIFT7);
   endfunction

   // One color channel of palette entry idx.
   function automatic logic [7:0] colour_pick(input logic [7:0] c0, input logic [7:0] c1,
                                              input logic [1:0] idx, input logic four);
      logic [7:0] v;
      logic [9:0] s2;
      logic [9:0] s3;
      logic [8:0] sh;
      s2 = {1'b0, c0, 1'b0} + 10'(c1);
      s3 = {1'b0, c1, 1'b0} + 10'(c0);
      sh = 9'(c0) + 9'(c1);
      case (idx)
         2'd0:    v = c0;
         2'd1:    v = c1;
         2'd2:    v = four ? div3(s2) : sh[8:1];
         default: v = four ? div3(s3) : 8'd0;
      endcase
      return v;
   endfunction

   // Entry idx of the interpolated alpha palette.
   function automatic logic [7:0] alpha_pick(input logic [7:0] a0, input logic [7:0] a1,
                                             input logic [2:0] idx);
      logic [7:0]  v;
      logic [2:0]  wa;
      logic [2:0]  wb;
      logic [10:0] sum;
      wa  = 3'(4'd8 - 4'(idx));
      wb  = idx - 3'd1;
      sum = 11'(wa) * 11'(a0) + 11'(wb) * 11'(a1);
      if (idx == 3'd0) begin
         v = a0;
      end else if (idx == 3'd1) begin
         v = a1;
      end else if (a0 > a1) begin
         v = div7(sum);
      end else if (idx == 3'd6) begin
         v = 8'd0;
      end else if (idx == 3'd7) begin
         v = 8'hff;
      end else begin
         // five-step weights are the seven-step ones less two on the first endpoint
         v = div5(sum - 11'({a0, 1'b0}));
      end
      return v;
   endfunction

endpackage

/* design/dxt_block_decoder.sv */
// DXT1/DXT3/DXT5 block decoder top level: block register, texel sequencer, result register.
//
//   Channel  Ports   Direction  Carries
//   request  req_*   in         one compressed block: four 32-bit words
//   response rsp_*   out        one RGBA8 texel, its raster index and a last flag
//   config   csr_*   in         block_format, written while idle
//
// A block yields sixteen response words, one per cycle while rsp_stall stays low; a new
// block is taken in the cycle its sixteenth texel moves to the result register, so the
// next block follows without a gap. The first texel passes through the block register and
// then the result register. Synchronous reset clears the format to DXT1 and empties
// both registers. rsp_stall on a waiting word freezes the result register and
// the sequencer; req_stall rises whenever the block register cannot take a new block.
module dxt_block_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_word_zero,
   input  logic [31:0] req_word_one,
   input  logic [31:0] req_word_two,
   input  logic [31:0] req_word_three,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_texel_index,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_alpha,
   output logic        rsp_last_texel
);

   logic [1:0]  block_format_ff;

   // block register
   logic        blk_valid_ff;
   logic [31:0] blk_w0_ff, blk_w1_ff, blk_w2_ff, blk_w3_ff;
   logic [dxt_pkg::TEXEL_BITS-1:0] texel_cnt_ff;

   // result register
   logic        rsp_valid_ff;
   logic [3:0]  rsp_texel_index_ff;
   logic [7:0]  rsp_red_ff, rsp_green_ff, rsp_blue_ff, rsp_alpha_ff;
   logic        rsp_last_texel_ff;

   logic        out_load;
   logic        blk_done;
   logic        req_take;

   logic [31:0] ep_word;
   logic [31:0] ci_word;
   logic [1:0]  ci;
   logic        four;
   dxt_pkg::rgb_type c0, c1;
   logic [7:0]  red_in, green_in, blue_in, alpha_in;
   logic [63:0] a4_bits;
   logic [47:0] a3_bits;
   logic [5:0]  a3_base;
   logic [2:0]  a3_idx;

   // advance the sequencer whenever the result register is free or draining
   assign out_load  = blk_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign blk_done  = out_load && (texel_cnt_ff == dxt_pkg::LAST_TEXEL);
   assign req_stall = blk_valid_ff && !blk_done;
   assign req_take  = req_valid && !req_stall;

   // DXT1 keeps endpoints and indices in the first two words
   assign ep_word = (block_format_ff == dxt_pkg::FMT_DXT1) ? blk_w0_ff : blk_w2_ff;
   assign ci_word = (block_format_ff == dxt_pkg::FMT_DXT1) ? blk_w1_ff : blk_w3_ff;
   assign ci      = ci_word[{texel_cnt_ff, 1'b0} +: 2];

   // explicit-alpha blocks always decode four colors
   assign four = (block_format_ff == dxt_pkg::FMT_DXT3) || (ep_word[15:0] > ep_word[31:16]);
   assign c0   = dxt_pkg::unpack565(ep_word[15:0]);
   assign c1   = dxt_pkg::unpack565(ep_word[31:16]);

   assign a4_bits = {blk_w1_ff, blk_w0_ff};
   assign a3_bits = {blk_w1_ff, blk_w0_ff[31:16]};
   assign a3_base = 6'(texel_cnt_ff) * 6'd3;
   assign a3_idx  = a3_bits[a3_base +: 3];

   always_comb begin
      red_in   = dxt_pkg::colour_pick(c0.red,   c1.red,   ci, four);
      green_in = dxt_pkg::colour_pick(c0.green, c1.green, ci, four);
      blue_in  = dxt_pkg::colour_pick(c0.blue,  c1.blue,  ci, four);
      case (block_format_ff)
         dxt_pkg::FMT_DXT1: begin
            // transparent black only on index three in three-color mode
            alpha_in = (ci == 2'd3 && !four) ? 8'd0 : 8'hff;
         end
         dxt_pkg::FMT_DXT3: begin
            alpha_in = dxt_pkg::widen4(a4_bits[{texel_cnt_ff, 2'b00} +: 4]);
         end
         default: begin
            // DXT5 and the spare code share the interpolated alpha path
            alpha_in = dxt_pkg::alpha_pick(blk_w0_ff[7:0], blk_w0_ff[15:8], a3_idx);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_format_ff <= dxt_pkg::FMT_DXT1;
         blk_valid_ff    <= 1'b0;
         texel_cnt_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write) begin
            block_format_ff <= csr_data;
         end

         if (req_take) begin
            blk_valid_ff <= 1'b1;
            texel_cnt_ff <= '0;
         end else if (blk_done) begin
            blk_valid_ff <= 1'b0;
            texel_cnt_ff <= '0;
         end else if (out_load) begin
            texel_cnt_ff <= texel_cnt_ff + dxt_pkg::TEXEL_BITS'(1);
         end

         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         blk_w0_ff <= req_word_zero;
         blk_w1_ff <= req_word_one;
         blk_w2_ff <= req_word_two;
         blk_w3_ff <= req_word_three;
      end
      if (out_load) begin
         rsp_texel_index_ff <= 4'(texel_cnt_ff);
         rsp_red_ff         <= red_in;
         rsp_green_ff       <= green_in;
         rsp_blue_ff        <= blue_in;
         rsp_alpha_ff       <= alpha_in;
         rsp_last_texel_ff  <= (texel_cnt_ff == dxt_pkg::LAST_TEXEL);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_texel_index = rsp_texel_index_ff;
   assign rsp_red         = rsp_red_ff;
   assign rsp_green       = rsp_green_ff;
   assign rsp_blue        = rsp_blue_ff;
   assign rsp_alpha       = rsp_alpha_ff;
   assign rsp_last_texel  = rsp_last_texel_ff;

endmodule

/* design/dxt_checker.sv */
// Port-level assertions for the DXT block decoder, bound to the top level.
module dxt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_texel_index,
   input logic [7:0]  rsp_red,
   input logic [7:0]  rsp_green,
   input logic [7:0]  rsp_blue,
   input logic [7:0]  rsp_alpha,
   input logic        rsp_last_texel
);

   // drop the response channel on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // hold a stalled word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_texel_index) && $stable(rsp_red)
         && $stable(rsp_green) && $stable(rsp_blue) && $stable(rsp_alpha)
         && $stable(rsp_last_texel))
      else $error("stalled response word changed");

   // last flag marks exactly the sixteenth texel
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_texel == (rsp_texel_index == 4'd15)))
      else $error("last flag out of step with texel index");

   // texels of a block follow without gaps and in raster order
   a_texel_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_texel
         |=> rsp_valid && (rsp_texel_index == $past(rsp_texel_index) + 4'd1))
      else $error("texel sequence broken inside a block");

endmodule

bind dxt_block_decoder dxt_checker u_dxt_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_texel_index (rsp_texel_index),
   .rsp_red         (rsp_red),
   .rsp_green       (rsp_green),
   .rsp_blue        (rsp_blue),
   .rsp_alpha       (rsp_alpha),
   .rsp_last_texel  (rsp_last_texel)
);

/* bench/dxt_texel_scoreboard.sv */
// Texel predictor and in-order scoreboard for the DXT block decoder bench.
package dxt_texel_check_pkg;
   timeunit 1ns;
   timeprecision 1ps;

   import dxt_pkg::*;

   typedef struct packed {
      bit [3:0] texel_index;
      bit [7:0] red;
      bit [7:0] green;
      bit [7:0] blue;
      bit [7:0] alpha;
      bit       last_texel;
   } texel_type;

   // Four palette entries, each {alpha, blue, green, red}.
   typedef bit [3:0][3:0][7:0] colour_set_type;

   class texel_scoreboard;
      bit [1:0]    block_format;
      texel_type   expected_texels[$];
      int unsigned failures;

      function new();
         block_format = FMT_DXT1;
         failures     = 0;
      endfunction

      function void set_format(bit [1:0] fmt);
         block_format = fmt;
      endfunction

      function int unsigned pending();
         return expected_texels.size();
      endfunction

      // Widen a short channel to 8 bits by repeating its top bits.
      static function bit [7:0] replicate(int unsigned v, int unsigned bits);
         return 8'(((v << (8 - bits)) | (v >> (2 * bits - 8))) & 'hff);
      endfunction

      static function colour_set_type build_colours(bit [31:0] w, bit force_four);
         colour_set_type pal;
         int unsigned lo;
         int unsigned hi;
         int unsigned c0;
         int unsigned c1;
         bit          four;
         lo   = w[15:0];
         hi   = w[31:16];
         four = force_four || (lo > hi);
         pal[0] = {8'hff, replicate(lo & 'h1f, 5), replicate((lo >> 5) & 'h3f, 6),
                   replicate((lo >> 11) & 'h1f, 5)};
         pal[1] = {8'hff, replicate(hi & 'h1f, 5), replicate((hi >> 5) & 'h3f, 6),
                   replicate((hi >> 11) & 'h1f, 5)};
         for (int ch = 0; ch < 3; ch++) begin
            c0 = pal[0][ch];
            c1 = pal[1][ch];
            if (four) begin
               pal[2][ch] = 8'((2 * c0 + c1) / 3);
               pal[3][ch] = 8'((2 * c1 + c0) / 3);
            end else begin
               pal[2][ch] = 8'((c0 + c1) / 2);
               pal[3][ch] = 8'h00;
            end
         end
         pal[2][3] = 8'hff;
         pal[3][3] = four ? 8'hff : 8'h00;
         return pal;
      endfunction

      // Decode one accepted block and queue its sixteen texels in raster order.
      function void note_block(bit [31:0] w0, bit [31:0] w1, bit [31:0] w2, bit [31:0] w3);
         colour_set_type pal;
         bit [7:0]    ramp [8];
         bit [63:0]   nibbles;
         bit [47:0]   codes;
         int unsigned a0;
         int unsigned a1;
         bit [1:0]    ci;
         texel_type   t;
         nibbles = {w1, w0};
         codes   = {w1, w0[31:16]};
         a0      = w0[7:0];
         a1      = w0[15:8];
         ramp[0] = 8'(a0);
         ramp[1] = 8'(a1);
         if (a0 > a1) begin
            for (int k = 1; k <= 6; k++)
               ramp[k + 1] = 8'(((7 - k) * a0 + k * a1) / 7);
         end else begin
            for (int k = 1; k <= 4; k++)
               ramp[k + 1] = 8'(((5 - k) * a0 + k * a1) / 5);
            ramp[6] = 8'h00;
            ramp[7] = 8'hff;
         end
         case (block_format)
            FMT_DXT1: pal = build_colours(w0, 1'b0);
            FMT_DXT3: pal = build_colours(w2, 1'b1);
            default:  pal = build_colours(w2, 1'b0);
         endcase
         for (int i = 0; i < TEXELS; i++) begin
            ci = (block_format == FMT_DXT1) ? w1[2 * i +: 2] : w3[2 * i +: 2];
            t.texel_index = 4'(i);
            t.red         = pal[ci][0];
            t.green       = pal[ci][1];
            t.blue        = pal[ci][2];
            case (block_format)
               FMT_DXT1: t.alpha = pal[ci][3];
               FMT_DXT3: t.alpha = replicate(nibbles[4 * i +: 4], 4);
               default:  t.alpha = ramp[codes[3 * i +: 3]];
            endcase
            t.last_texel = (i == TEXELS - 1);
            expected_texels.insert(expected_texels.size(), t);
         end
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned seen);
         if (want != seen) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, seen);
            failures++;
         end
      endfunction

      function void check_texel(texel_type seen);
         texel_type want;
         if (expected_texels.size() == 0) begin
            $display("%0t ns: texel %0d rgba %h arrived with nothing expected", $time,
                     seen.texel_index, {seen.red, seen.green, seen.blue, seen.alpha});
            failures++;
            return;
         end
         want = expected_texels.pop_front();
         compare_field("texel_index", want.texel_index, seen.texel_index);
         compare_field("red", want.red, seen.red);
         compare_field("green", want.green, seen.green);
         compare_field("blue", want.blue, seen.blue);
         compare_field("alpha", want.alpha, seen.alpha);
         compare_field("last_texel", want.last_texel, seen.last_texel);
      endfunction
   endclass

endpackage

/* bench/tb_top.sv */
// Self-checking bench for dxt_block_decoder: directed and random blocks in every format.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import dxt_pkg::*;
   import dxt_texel_check_pkg::*;

   // csr_data is two bits wide, so the unused format code is reachable too
   localparam logic [1:0]  FMT_SPARE      = 2'd3;
   localparam int unsigned RESET_CYCLES   = 7;
   localparam int unsigned SETTLE_CYCLES  = 8;
   localparam int unsigned HOLD_CYCLES    = 300;
   localparam int unsigned RANDOM_PHASES  = 9;
   localparam int unsigned PHASE_BLOCKS   = 20;
   localparam int unsigned CYCLE_LIMIT    = 1000000;
   // Format of random phase p sits at bits 2p+1:2p.
   localparam bit [17:0] FORMAT_PLAN = {FMT_DXT1, FMT_DXT5, FMT_DXT1, FMT_DXT3, FMT_DXT5,
                                        FMT_SPARE, FMT_DXT5, FMT_DXT3, FMT_DXT1};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_data = FMT_DXT1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_word_zero = '0;
   logic [31:0] req_word_one = '0;
   logic [31:0] req_word_two = '0;
   logic [31:0] req_word_three = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_texel_index;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic [7:0]  rsp_alpha;
   logic        rsp_last_texel;

   texel_scoreboard texel_board;
   bit              steady = 1'b0;     // no idling on either side while set
   int unsigned     hold_requests = 0; // bumped by the sender to ask for a long hold-off
   int unsigned     cycle_count = 0;

   dxt_block_decoder dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_word_zero  (req_word_zero),
      .req_word_one   (req_word_one),
      .req_word_two   (req_word_two),
      .req_word_three (req_word_three),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_texel_index(rsp_texel_index),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_alpha      (rsp_alpha),
      .rsp_last_texel (rsp_last_texel)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Idle stretch length: mostly short, now and then long.
   function automatic int unsigned idle_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 3);
      else if (r < 95)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Offer one block and hold it until the decoder takes it. Valid is only
   // lowered when a gap precedes this word, so back-to-back words never see
   // a low-then-high pair of assignments in one step.
   task automatic send_block(input bit [31:0] w0, input bit [31:0] w1,
                             input bit [31:0] w2, input bit [31:0] w3);
      int unsigned gap;
      gap = (steady || $urandom_range(0, 1) == 0) ? 0 : idle_length();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_word_zero  <= w0;
      req_word_one   <= w1;
      req_word_two   <= w2;
      req_word_three <= w3;
      // req_stall read here is the value the decoder saw at this edge
      do @(posedge clock); while (req_stall);
      texel_board.note_block(w0, w1, w2, w3);
   endtask

   // DXT5 helper: pack the alpha endpoints and the 48-bit index field.
   task automatic send_dxt5(input bit [7:0] a0, input bit [7:0] a1, input bit [47:0] codes,
                            input bit [31:0] w2, input bit [31:0] w3);
      send_block({codes[15:0], a1, a0}, codes[47:16], w2, w3);
   endtask

   // Random block, now and then steered onto equal endpoints or all-ones/all-zeros words.
   task automatic send_random_block();
      bit [31:0]   w [4];
      int unsigned pick;
      for (int k = 0; k < 4; k++)
         w[k] = $urandom();
      pick = $urandom_range(0, 9);
      case (pick)
         0: begin
            if (texel_board.block_format == FMT_DXT1)
               w[0][31:16] = w[0][15:0];
            else
               w[2][31:16] = w[2][15:0];
         end
         1: w[0][15:8] = w[0][7:0];
         2: w[$urandom_range(0, 3)] = '1;
         3: w[$urandom_range(0, 3)] = '0;
         default: ;
      endcase
      send_block(w[0], w[1], w[2], w[3]);
   endtask

   // Drop valid and wait until every queued texel has come back, then let the
   // pipeline settle before anyone touches the format register.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (texel_board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic change_format(input bit [1:0] fmt);
      drain_results();
      csr_write <= 1'b1;
      csr_data  <= fmt;
      @(posedge clock);
      texel_board.set_format(fmt);
      csr_write <= 1'b0;
   endtask

   // Sender: reset, directed blocks per format, then random phases.
   initial begin
      bit [1:0] fmt;
      texel_board = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // DXT1 straight out of reset: endpoints in word zero, indices in word one.
      send_block(32'h0, 32'h0, 32'h0, 32'h0);                      // equal endpoints, black
      send_block('1, '1, '1, '1);                                  // equal endpoints, transparent
      send_block({16'h001f, 16'hf800}, 32'he4e4e4e4, 32'h5a5a5a5a, 32'ha5a5a5a5); // four colors
      send_block({16'hffe0, 16'h07ff}, 32'he4e4e4e4, 32'h0, 32'h0);  // three colors + transparent
      send_block({16'h0000, 16'hffff}, 32'h1b1b1b1b, 32'h0, '1);     // extreme endpoints

      // DXT3: explicit alpha nibbles, color always four-entry even when e0 <= e1.
      change_format(FMT_DXT3);
      send_block(32'h0, 32'h0, 32'h0, 32'h0);
      send_block('1, '1, '1, '1);
      send_block(32'h76543210, 32'hfedcba98, {16'hf81f, 16'h07e0}, 32'he4e4e4e4);

      // DXT5: sevenths, fifths with the 0/255 entries, equal endpoints, and
      // the top bit of the last alpha index on its own.
      change_format(FMT_DXT5);
      send_dxt5(8'hff, 8'h00, 48'o7654321076543210, {16'h001f, 16'hf800}, 32'he4e4e4e4);
      send_dxt5(8'h00, 8'hff, 48'o7654321076543210, {16'hffe0, 16'h07ff}, 32'he4e4e4e4);
      send_dxt5(8'h80, 8'h80, 48'hffff_ffff_ffff, {16'h1234, 16'h1234}, '1);
      send_dxt5(8'h40, 8'hc3, 48'o0123456701234567, {16'h07e0, 16'hf81f}, 32'h1b1b1b1b);
      send_dxt5(8'h10, 8'hf0, 48'h8000_0000_0000, 32'h0, 32'h0);
      send_block(32'h0, 32'h0, 32'h0, 32'h0);
      send_block('1, '1, '1, '1);

      // Unused format code decodes as DXT5.
      change_format(FMT_SPARE);
      send_dxt5(8'hff, 8'h00, 48'o7654321076543210, {16'hffe0, 16'h07ff}, 32'he4e4e4e4);
      send_random_block();

      for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
         fmt = FORMAT_PLAN[2 * phase +: 2];
         change_format(fmt);
         steady = (phase == 2 || phase == 6);
         // Long receiver hold-off while blocks keep coming: fills the decoder
         // and pushes req_stall high.
         if (phase == 4)
            hold_requests++;
         for (int unsigned n = 0; n < PHASE_BLOCKS; n++) begin
            // Pause the sender mid-phase until the decoder has fully drained.
            if (phase == 1 && n == PHASE_BLOCKS / 2)
               drain_results();
            send_random_block();
         end
      end
      steady = 1'b0;

      drain_results();
      if (texel_board.failures == 0)
         $display("dxt_block_decoder regression: pass");
      else
         $display("dxt_block_decoder regression: fail");
      $finish;
   end

   // Receiver: check each accepted texel word, then pick next cycle's stall.
   always @(posedge clock) begin : response_side
      texel_type   seen;
      int unsigned stall_left;
      int unsigned hold_served;
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.texel_index = rsp_texel_index;
         seen.red         = rsp_red;
         seen.green       = rsp_green;
         seen.blue        = rsp_blue;
         seen.alpha       = rsp_alpha;
         seen.last_texel  = rsp_last_texel;
         texel_board.check_texel(seen);
      end
      // Serve a hold-off request by counting it down here.
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         stall_left  = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (steady || $urandom_range(0, 99) < 65) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_left = idle_length() - 1;
         rsp_stall <= 1'b1;
      end
   end

   // Watchdog: stop a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("dxt_block_decoder regression: fail");
         $finish;
      end
   end

endmodule

/* dxt_block_decoder.f */
design/dxt_pkg.sv
design/dxt_block_decoder.sv
design/dxt_checker.sv
bench/dxt_texel_scoreboard.sv
bench/tb_top.sv
